// ----- hw/rtl/irt_pkg.sv -----
// Shared types, constants and a helper function for the integer to radix token converter.
package irt_pkg;

    localparam int MAX_DIGITS_DEF = 32;
    localparam int RADIX_BITS     = 16;
    localparam int MAX_TOKENS     = 32;
    localparam int DIV_STEPS      = 31;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 40;

    localparam logic [15:0] RADIX_MASK = 16'((64'd1 << RADIX_BITS) - 64'd1);
    localparam logic [15:0] MIN_RADIX  = 16'd2;
    localparam logic [15:0] BASE62     = 16'd62;

    // Reciprocals of 62 for a 16-bit and an 11-bit dividend, scaled by 2**22 and 2**16.
    localparam logic [16:0] RECIP62_HI = 17'd67651;
    localparam logic [10:0] RECIP62_LO = 11'd1058;

    localparam logic [6:0] CH_ZERO   = 7'd48;
    localparam logic [6:0] CH_OPEN   = 7'd40;
    localparam logic [6:0] CH_CLOSE  = 7'd41;
    localparam logic [6:0] CH_MINUS  = 7'd45;
    localparam logic [6:0] OFS_UPPER = 7'd55;
    localparam logic [6:0] OFS_LOWER = 7'd61;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_DIGIT,
        ST_SUB1,
        ST_SUB2,
        ST_PUT
    } irt_state_t;

    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] dx;
        dx = {1'b0, d};
        if (d < 6'd10) begin
            return CH_ZERO + dx;
        end
        else if (d < 6'd36) begin
            return OFS_UPPER + dx;
        end
        else begin
            return OFS_LOWER + dx;
        end
    endfunction

endpackage

// ----- hw/rtl/integer_to_radix_tokens.sv -----
// Top level of the integer to radix token converter.
//
// The input channel (s_tvalid, s_tready, s_tdata) takes one item: a signed
// 32-bit value and a 16-bit radix. The output channel (m_tvalid, m_tready,
// m_tdata, m_tlast) returns the tokens of that number, most significant digit
// first, with m_tlast on the final token. A negative number gets a leading
// minus token, and zero gives a single "0" token. The cfg_we/cfg_wdata port
// writes the bracket mode bit, which resets to bracketed tokens.
// The digits come from one bit-serial divider, and all digits of an item are
// divided out before its first token. A plain digit of 62 or more is skipped,
// and a bracketed digit of 62 or more is split into base-62 sub-digits by
// reciprocal multiplication. The input is not ready until the last token of
// the item has been placed in the output register.
// A stall on m_tready holds the current token, and the block waits with the
// next token until the output register is free.
// Reset empties the output register and returns the block to idle.
module integer_to_radix_tokens #(
    parameter int MAX_DIGITS = irt_pkg::MAX_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: value[31:0], radix[47:32].
    input  logic [irt_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: token_length[2:0], char0..char4 at 7 bits each, zero pad.
    output logic [irt_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata
);

    import irt_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
    localparam logic [5:0] TOK_LAST_IDX = 6'(MAX_TOKENS - 1);
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    irt_state_t state_reg, state_next;

    logic             bracket_reg;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] digit_cnt_reg, digit_cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             any_emit_reg, any_emit_next;
    logic [IDX_W-1:0] low_emit_reg, low_emit_next;
    logic [5:0]       tok_cnt_reg, tok_cnt_next;
    logic [5:0]       sub0_reg, sub0_next;
    logic [10:0]      sub_q_reg, sub_q_next;

    logic [4:0]       div_cnt_reg, div_cnt_next;
    logic [15:0]      div_r_reg, div_r_next;
    logic [15:0]      div_d_reg, div_d_next;
    logic [30:0]      div_q_reg, div_q_next;

    logic [2:0]       tok_len_reg, tok_len_next;
    logic [6:0]       tok_reg [5];
    logic [6:0]       tok_next [5];
    logic             tok_last_reg, tok_last_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_last_reg, m_last_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic [15:0]      digit_mem [MAX_DIGITS];
    logic [15:0]      rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_raddr;

    logic [16:0]      div_shift;
    logic             div_ge;
    logic [15:0]      div_r_new;
    logic [30:0]      div_q_new;
    logic             div_done;

    logic [32:0]      sub_prod1;
    logic [10:0]      sub_q1;
    logic [15:0]      sub_r1;
    logic [21:0]      sub_prod2;
    logic [5:0]       sub_q2;
    logic [15:0]      sub_r2;

    logic [31:0]      in_value;
    logic [15:0]      in_radix;
    logic [31:0]      in_mag32;
    logic [30:0]      in_mag;
    logic             accept;
    logic             out_free;
    logic             d_small;
    logic             emit_new;
    logic [CNT_W-1:0] cnt_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    assign div_shift = {div_r_reg, div_q_reg[30]};
    assign div_ge    = div_shift >= {1'b0, div_d_reg};
    assign div_r_new = div_ge ? 16'(div_shift - {1'b0, div_d_reg}) : div_shift[15:0];
    assign div_q_new = {div_q_reg[29:0], div_ge};
    assign div_done  = (div_cnt_reg == DIV_LAST);

    assign sub_prod1 = 33'(rd_data_reg) * 33'(RECIP62_HI);
    assign sub_q1    = sub_prod1[32:22];
    assign sub_r1    = rd_data_reg - {5'd0, sub_q1} * BASE62;
    assign sub_prod2 = 22'(sub_q_reg) * 22'(RECIP62_LO);
    assign sub_q2    = sub_prod2[21:16];
    assign sub_r2    = {5'd0, sub_q_reg} - {10'd0, sub_q2} * BASE62;

    assign in_value = s_tdata[31:0];
    assign in_mag32 = in_value[31] ? (32'd0 - in_value) : in_value;
    assign in_mag   = in_mag32[31] ? 31'h7FFF_FFFF : in_mag32[30:0];

    always_comb
    begin
        in_radix = s_tdata[47:32] & RADIX_MASK;
        if (in_radix < MIN_RADIX)
        begin
            in_radix = MIN_RADIX;
        end
    end

    assign d_small   = rd_data_reg < BASE62;
    assign emit_new  = bracket_reg || (div_r_new < BASE62);
    assign cnt_inc   = digit_cnt_reg + CNT_W'(1);
    assign mem_we    = (state_reg == ST_DIV) && div_done;
    assign mem_raddr = IDX_W'(idx_reg - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[digit_cnt_reg[IDX_W-1:0]] <= div_r_new;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= digit_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_mag == 31'd0) ? ST_PUT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done && ((div_q_new == 31'd0) || (cnt_inc == CNT_MAX)))
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (neg_reg)
                begin
                    state_next = ST_PUT;
                end
                else if (any_emit_reg)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = (idx_reg == '0) ? ST_IDLE : ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (d_small)
                begin
                    state_next = ST_PUT;
                end
                else if (bracket_reg)
                begin
                    state_next = ST_SUB1;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_SUB1:
            begin
                state_next = ({5'd0, sub_q1} < BASE62) ? ST_PUT : ST_SUB2;
            end
            ST_SUB2:
            begin
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = (tok_last_reg || (tok_cnt_reg == TOK_LAST_IDX)) ?
                                 ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        neg_next       = neg_reg;
        digit_cnt_next = digit_cnt_reg;
        idx_next       = idx_reg;
        any_emit_next  = any_emit_reg;
        low_emit_next  = low_emit_reg;
        tok_cnt_next   = tok_cnt_reg;
        sub0_next      = sub0_reg;
        sub_q_next     = sub_q_reg;
        div_cnt_next   = div_cnt_reg;
        div_r_next     = div_r_reg;
        div_d_next     = div_d_reg;
        div_q_next     = div_q_reg;
        tok_len_next   = tok_len_reg;
        tok_next       = tok_reg;
        tok_last_next  = tok_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_last_next    = m_last_reg;
        m_data_next    = m_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    digit_cnt_next = '0;
                    any_emit_next  = 1'b0;
                    tok_cnt_next   = '0;
                    div_cnt_next   = '0;
                    div_r_next     = '0;
                    div_d_next     = in_radix;
                    div_q_next     = in_mag;
                    if (in_mag == 31'd0)
                    begin
                        neg_next      = 1'b0;
                        tok_len_next  = 3'd1;
                        tok_next      = '{CH_ZERO, 7'd0, 7'd0, 7'd0, 7'd0};
                        tok_last_next = 1'b1;
                    end
                    else
                    begin
                        neg_next = in_value[31];
                    end
                end
            end
            ST_DIV:
            begin
                div_r_next   = div_r_new;
                div_q_next   = div_q_new;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_done)
                begin
                    digit_cnt_next = cnt_inc;
                    idx_next       = cnt_inc;
                    div_cnt_next   = '0;
                    div_r_next     = '0;
                    if (!any_emit_reg && emit_new)
                    begin
                        any_emit_next = 1'b1;
                        low_emit_next = digit_cnt_reg[IDX_W-1:0];
                    end
                end
            end
            ST_SIGN:
            begin
                tok_len_next  = 3'd1;
                tok_next      = '{CH_MINUS, 7'd0, 7'd0, 7'd0, 7'd0};
                tok_last_next = !any_emit_reg;
            end
            ST_READ:
            begin
                idx_next = idx_reg - CNT_W'(1);
            end
            ST_DIGIT:
            begin
                tok_last_next = (idx_reg[IDX_W-1:0] == low_emit_reg);
                if (d_small)
                begin
                    if (bracket_reg)
                    begin
                        tok_len_next = 3'd3;
                        tok_next     = '{CH_OPEN, digit_char(rd_data_reg[5:0]), CH_CLOSE,
                                         7'd0, 7'd0};
                    end
                    else
                    begin
                        tok_len_next = 3'd1;
                        tok_next     = '{digit_char(rd_data_reg[5:0]), 7'd0, 7'd0,
                                         7'd0, 7'd0};
                    end
                end
            end
            ST_SUB1:
            begin
                sub0_next    = sub_r1[5:0];
                sub_q_next   = sub_q1;
                tok_len_next = 3'd4;
                tok_next     = '{CH_OPEN, digit_char(sub_q1[5:0]),
                                 digit_char(sub_r1[5:0]), CH_CLOSE, 7'd0};
            end
            ST_SUB2:
            begin
                tok_len_next = 3'd5;
                tok_next     = '{CH_OPEN, digit_char(sub_q2),
                                 digit_char(sub_r2[5:0]), digit_char(sub0_reg),
                                 CH_CLOSE};
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_last_next  = tok_last_reg || (tok_cnt_reg == TOK_LAST_IDX);
                    m_data_next  = {2'b00, tok_reg[4], tok_reg[3], tok_reg[2],
                                    tok_reg[1], tok_reg[0], tok_len_reg};
                    tok_cnt_next = tok_cnt_reg + 6'd1;
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bracket_reg   <= 1'b1;
            neg_reg       <= 1'b0;
            digit_cnt_reg <= '0;
            idx_reg       <= '0;
            any_emit_reg  <= 1'b0;
            tok_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            tok_last_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                bracket_reg <= cfg_wdata;
            end
            neg_reg       <= neg_next;
            digit_cnt_reg <= digit_cnt_next;
            idx_reg       <= idx_next;
            any_emit_reg  <= any_emit_next;
            tok_cnt_reg   <= tok_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            tok_last_reg  <= tok_last_next;
            m_valid_reg   <= m_valid_next;
            m_last_reg    <= m_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_emit_reg <= low_emit_next;
        sub0_reg     <= sub0_next;
        sub_q_reg    <= sub_q_next;
        div_r_reg    <= div_r_next;
        div_d_reg    <= div_d_next;
        div_q_reg    <= div_q_next;
        tok_len_reg  <= tok_len_next;
        tok_reg      <= tok_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the integer to radix token converter: directed table, then random items.
`timescale 1ns / 100ps

module tb;
    import irt_pkg::*;

    localparam int CYCLE_LIMIT      = 4000000;
    localparam int SETTLE_CYCLES    = 1500;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int LONG_HOLD        = 3000;

    typedef struct packed {
        logic            last;
        logic [4:0][6:0] ch;
        logic [2:0]      len;
    } token_t;

    typedef struct {
        logic        bracketed;
        logic [31:0] value;
        logic [15:0] radix;
        string       typed;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic                  cfg_wdata;

    token_t pending_tokens[$];
    int     fail_count  = 0;
    int     tokens_seen = 0;
    int     burst_left  = 0;
    string  typed_now   = "*";

    logic [15:0] digit_buf [MAX_DIGITS_DEF];
    logic        mode_copy   = 1'b1;

    integer_to_radix_tokens dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [6:0] digit_glyph(input logic [15:0] d);
        if (d < 16'd10)
        begin
            return 7'(CH_ZERO + d);
        end
        else if (d < 16'd36)
        begin
            return 7'(OFS_UPPER + d);
        end
        return 7'(OFS_LOWER + d);
    endfunction

    task automatic spell_number(input logic [31:0] v, input logic [15:0] r,
                                output token_t row [MAX_TOKENS], output int n);
        logic [15:0] base;
        logic [31:0] mag;
        logic [15:0] d;
        logic [15:0] t;
        logic [6:0]  sub [3];
        int          cnt;
        int          k;
        int          pos;
        token_t      tk;
        n = 0;
        base = r & RADIX_MASK;
        if (base < MIN_RADIX)
        begin
            base = MIN_RADIX;
        end
        mag = v[31] ? -v : v;
        if (mag > 32'h7FFF_FFFF)
        begin
            mag = 32'h7FFF_FFFF;
        end
        if (mag == 32'd0)
        begin
            tk          = '0;
            tk.len      = 3'd1;
            tk.ch[0]    = CH_ZERO;
            row[0]      = tk;
            n           = 1;
            return;
        end
        cnt = 0;
        while (mag != 32'd0 && cnt < MAX_DIGITS_DEF)
        begin
            digit_buf[cnt] = 16'(mag % base);
            mag = mag / base;
            cnt++;
        end
        if (v[31])
        begin
            tk       = '0;
            tk.len   = 3'd1;
            tk.ch[0] = CH_MINUS;
            row[n]   = tk;
            n++;
        end
        for (int i = cnt - 1; i >= 0; i--)
        begin
            d  = digit_buf[i];
            tk = '0;
            if (mode_copy)
            begin
                tk.ch[0] = CH_OPEN;
                pos = 1;
                if (d < BASE62)
                begin
                    tk.ch[1] = digit_glyph(d);
                    pos = 2;
                end
                else
                begin
                    t = d;
                    k = 0;
                    while (t != 16'd0 && k < 3)
                    begin
                        sub[k] = digit_glyph(t % BASE62);
                        t = t / BASE62;
                        k++;
                    end
                    while (k > 0)
                    begin
                        k--;
                        tk.ch[pos] = sub[k];
                        pos++;
                    end
                end
                tk.ch[pos] = CH_CLOSE;
                tk.len = 3'(pos + 1);
                if (n < MAX_TOKENS)
                begin
                    row[n] = tk;
                    n++;
                end
            end
            else if (d < BASE62)
            begin
                tk.len   = 3'd1;
                tk.ch[0] = digit_glyph(d);
                if (n < MAX_TOKENS)
                begin
                    row[n] = tk;
                    n++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        token_t row [MAX_TOKENS];
        token_t tk;
        token_t got;
        int     n;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (typed_now == "*")
                begin
                    spell_number(s_tdata[31:0], s_tdata[47:32], row, n);
                end
                else
                begin
                    // Tokens of a typed row are separated by spaces.
                    n  = 0;
                    tk = '0;
                    for (int i = 0; i < typed_now.len(); i++)
                    begin
                        if (typed_now[i] == " ")
                        begin
                            row[n] = tk;
                            n++;
                            tk = '0;
                        end
                        else
                        begin
                            tk.ch[tk.len] = 7'(typed_now[i]);
                            tk.len = tk.len + 3'd1;
                        end
                    end
                    if (tk.len != 3'd0)
                    begin
                        row[n] = tk;
                        n++;
                    end
                end
                if (n > 0)
                begin
                    row[n - 1].last = 1'b1;
                end
                for (int i = 0; i < n; i++)
                begin
                    pending_tokens.push_back(row[i]);
                end
            end
            if (m_tvalid && m_tready)
            begin
                got = token_t'({m_tlast, m_tdata[37:0]});
                tokens_seen++;
                if (pending_tokens.size() == 0)
                begin
                    $error("unexpected token: tdata %h tlast %b", m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    tk = pending_tokens.pop_front();
                    if (got.len != tk.len)
                    begin
                        $error("token_length: expected %0d, actual %0d", tk.len, got.len);
                        fail_count++;
                    end
                    for (int i = 0; i < 5; i++)
                    begin
                        if (got.ch[i] != tk.ch[i])
                        begin
                            $error("char%0d: expected %0d, actual %0d", i, tk.ch[i], got.ch[i]);
                            fail_count++;
                        end
                    end
                    if (got.last != tk.last)
                    begin
                        $error("last_token: expected %0d, actual %0d", tk.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                mode_copy = cfg_wdata;
            end
        end
    end

    task automatic offer(input logic [31:0] v, input logic [15:0] r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tdata  <= {r, v};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_tokens.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : receiver
        int hold_left;
        int pattern;
        int tick;
        bit held_once;
        hold_left = 0;
        pattern   = 0;
        tick      = 0;
        held_once = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held_once && tokens_seen >= 300)
            begin
                held_once = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
            begin
                if (tick % 64 == 0)
                begin
                    pattern = $urandom_range(0, 2);
                end
                case (pattern)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t   plan [$];
        logic [31:0] v;
        logic [15:0] r;
        logic        cur_mode;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;

        // Bracketed rows rely on the mode after reset.
        plan.push_back('{1'b1, 32'd0,          16'd10,    "0"});
        plan.push_back('{1'b1, 32'd1,          16'd10,    "(1)"});
        plan.push_back('{1'b1, 32'hFFFF_FFFF,  16'd10,    "- (1)"});
        plan.push_back('{1'b1, 32'd35,         16'd36,    "(Z)"});
        plan.push_back('{1'b1, 32'd61,         16'd62,    "(z)"});
        plan.push_back('{1'b1, 32'd62,         16'd63,    "(10)"});
        plan.push_back('{1'b1, 32'd5,          16'd0,     "(1) (0) (1)"});
        plan.push_back('{1'b1, 32'd6,          16'd1,     "(1) (1) (0)"});
        plan.push_back('{1'b1, 32'h7FFF_FFFF,  16'd2,     "*"});
        plan.push_back('{1'b1, 32'h8000_0001,  16'd2,     "*"});
        plan.push_back('{1'b1, 32'h8000_0000,  16'd10,    "*"});
        plan.push_back('{1'b1, 32'd65534,      16'd65535, "*"});
        plan.push_back('{1'b1, 32'h7FFF_FFFF,  16'd65535, "*"});
        plan.push_back('{1'b1, 32'h8000_0000,  16'd65535, "*"});
        plan.push_back('{1'b1, 32'd12345,      16'd10,    "*"});
        plan.push_back('{1'b0, 32'd0,          16'd10,    "0"});
        plan.push_back('{1'b0, 32'd100,        16'd200,   ""});
        plan.push_back('{1'b0, 32'hFFFF_FF9C,  16'd200,   "-"});
        plan.push_back('{1'b0, 32'd35,         16'd36,    "Z"});
        plan.push_back('{1'b0, 32'd123,        16'd62,    "1 z"});
        plan.push_back('{1'b0, 32'h8000_0000,  16'd2,     "*"});
        plan.push_back('{1'b0, 32'h7FFF_FFFF,  16'd65535, "*"});
        plan.push_back('{1'b0, -32'sd987654321, 16'd16,   "*"});
        plan.push_back('{1'b0, 32'd3,          16'd0,     "1 1"});

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        cur_mode = 1'b1;
        foreach (plan[i])
        begin
            if (plan[i].bracketed != cur_mode)
            begin
                settle();
                write_mode(plan[i].bracketed);
                cur_mode = plan[i].bracketed;
            end
            typed_now = plan[i].typed;
            offer(plan[i].value, plan[i].radix);
        end

        typed_now = "*";
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            cur_mode = (phase % 2 == 0);
            write_mode(cur_mode);
            repeat (RANDOM_PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = $urandom;
                    4, 5:       v = $urandom_range(0, 1000);
                    6:
                    begin
                        case ($urandom_range(0, 4))
                            0:       v = 32'd0;
                            1:       v = 32'h7FFF_FFFF;
                            2:       v = 32'h8000_0000;
                            3:       v = 32'h8000_0001;
                            default: v = 32'hFFFF_FFFF;
                        endcase
                    end
                    default:    v = $urandom >> $urandom_range(0, 31);
                endcase
                if ($urandom_range(0, 2) == 0)
                begin
                    v = -v;
                end
                case ($urandom_range(0, 9))
                    0:          r = 16'($urandom_range(0, 3));
                    1, 2, 3:    r = 16'($urandom_range(2, 16));
                    4, 5:       r = 16'($urandom_range(17, 100));
                    6, 7:       r = 16'($urandom_range(101, 4000));
                    default:    r = 16'($urandom_range(4001, 65535));
                endcase
                offer(v, r);
            end
        end
        settle();

        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- integer_to_radix_tokens.f -----
hw/rtl/irt_pkg.sv
hw/rtl/integer_to_radix_tokens.sv
tb/tb.sv
